FILE: rtl/ipdd_pkg.sv
// ipdd_pkg: widths and fixed constants of the incremental pid dac drive
// used by ipdd_mul and incremental_pid_dac_drive; no dependencies
`default_nettype none

package ipdd_pkg;

    // word fields
    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int DRIVE_W = 32;
    localparam int DAC_W   = 12;

    // internal arithmetic widths
    localparam int ERR_W  = SPEED_W + 1;   // command minus measurement
    localparam int D1_W   = ERR_W + 1;     // first difference
    localparam int D2_W   = ERR_W + 2;     // second difference
    localparam int MUL_W  = 20;            // shared multiplier operand width
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 38;            // drive plus three terms, no overflow

    // config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd2;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd256;

    // dac scale 4095 / 6.554 applied to q16.16 volts, reduced by 8
    localparam longint DAC_FULL_NUM  = 4095000;
    localparam longint DAC_FULL_DEN  = 6554 * 65536;
    localparam longint DAC_SCALE_NUM = DAC_FULL_NUM / 8;
    localparam longint DAC_SCALE_DEN = DAC_FULL_DEN / 8;
    localparam longint DAC_CODE_SPAN = longint'(1) << DAC_W;

    // smallest drive whose code reaches the span
    localparam logic [DRIVE_W-1:0] DAC_CLAMP_DRIVE = DRIVE_W'(
        (DAC_CODE_SPAN * DAC_SCALE_DEN + DAC_SCALE_NUM - 1) / DAC_SCALE_NUM);

    localparam logic [DAC_W-1:0] DAC_CODE_MAX = {DAC_W{1'b1}};

    localparam logic signed [MUL_W-1:0] SCALE_MULT = MUL_W'(DAC_SCALE_NUM);

    // reciprocal of the scale; below the clamp drive the estimate is low by at most one
    localparam int     DAC_RECIP_SHIFT = 25;
    localparam longint DAC_RECIP =
        ((longint'(1) << DAC_RECIP_SHIFT) * DAC_SCALE_NUM) / DAC_SCALE_DEN;
    localparam logic signed [MUL_W-1:0] RECIP_MULT = MUL_W'(DAC_RECIP);

    // divisor split into an odd factor and a power of two
    localparam int     DAC_DEN_SHIFT = 14;
    localparam longint DAC_DEN_ODD   = DAC_SCALE_DEN >> DAC_DEN_SHIFT;
    localparam logic signed [MUL_W-1:0] DEN_ODD_MULT = MUL_W'(DAC_DEN_ODD);
    localparam logic [PROD_W-1:0] DAC_DIVISOR = PROD_W'(DAC_SCALE_DEN);

endpackage

`default_nettype wire

FILE: rtl/ipdd_mul.sv
// ipdd_mul: registered signed multiplier shared by the gain terms and dac scaling
// depends on ipdd_pkg
`default_nettype none

module ipdd_mul
    import ipdd_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [MUL_W-1:0]  a,
    input  wire logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // one product per enabled cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: rtl/incremental_pid_dac_drive.sv
// incremental_pid_dac_drive: velocity-form pid speed loop with a 12-bit dac code
// depends on ipdd_pkg and ipdd_mul
//
// One word in (commanded and measured speed, signed q8.8) gives one word out:
// the saturated q16.16 drive, its 12-bit dac code and a clamp flag. The block
// holds one word at a time and drops s_ready while it works. A word whose dac
// code clamps to 0 or 4095 skips the scaling steps and reaches m_valid sooner
// than one inside its range, and the block passes through idle before the
// next word is taken. The work is done by one registered 20x20 multiplier that
// forms in turn the three gain terms, a reciprocal estimate of the dac code, the
// exact scaling product and the estimate times the divisor; a final compare
// raises the estimate by one where it falls short. The result sits in an output
// register, so the next word can be accepted while it waits for m_ready. Gain
// writes on the cfg port are always taken and are meant for idle periods.
`default_nettype none

module incremental_pid_dac_drive
    import ipdd_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // config write channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [GAIN_W-1:0]           cfg_data,
    // speed input
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [SPEED_W-1:0]   s_commanded_speed,
    input  wire logic signed [SPEED_W-1:0]   s_measured_speed,
    // drive output
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [DAC_W-1:0]                 m_dac_code,
    output logic signed [DRIVE_W-1:0]        m_drive_volts,
    output logic                             m_dac_clamped
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_ADD,
        S_SAT,
        S_SCALE,
        S_EST,
        S_LOAD,
        S_FIX,
        S_DONE
    } state_t;

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0] kp_reg, kp_next;
    logic [GAIN_W-1:0] ki_reg, ki_next;
    logic [GAIN_W-1:0] kd_reg, kd_next;

    logic signed [DRIVE_W-1:0] prev_drive_reg, prev_drive_next;
    logic signed [ERR_W-1:0]   e1_reg, e1_next;
    logic signed [ERR_W-1:0]   e2_reg, e2_next;

    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [D1_W-1:0]    d1_reg, d1_next;
    logic signed [D2_W-1:0]    d2_reg, d2_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [1:0]                term_reg, term_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;

    logic [PROD_W-1:0]         rem_reg, rem_next;
    logic [DAC_W-1:0]          quo_reg, quo_next;
    logic [DAC_W-1:0]          code_reg, code_next;
    logic                      clamp_reg, clamp_next;

    logic                      m_valid_reg, m_valid_next;
    logic [DAC_W-1:0]          m_code_reg, m_code_next;
    logic signed [DRIVE_W-1:0] m_drive_reg, m_drive_next;
    logic                      m_clamp_reg, m_clamp_next;

    logic                      mul_en;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_prod;

    logic                      acc_fits;
    logic [PROD_W-1:0]         fix_rem;
    logic                      fix_up;

    // shared multiplier
    ipdd_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    assign acc_fits = (&acc_reg[ACC_W-1:DRIVE_W-1]) | ~(|acc_reg[ACC_W-1:DRIVE_W-1]);

    // scaling product less estimate times divisor; one more divisor means estimate is short
    assign fix_rem = rem_reg - ($unsigned(mul_prod) << DAC_DEN_SHIFT);
    assign fix_up  = (fix_rem >= DAC_DIVISOR);

    // sequencer and datapath next values
    always_comb begin
        state_next      = state_reg;
        kp_next         = kp_reg;
        ki_next         = ki_reg;
        kd_next         = kd_reg;
        prev_drive_next = prev_drive_reg;
        e1_next         = e1_reg;
        e2_next         = e2_reg;
        err_next        = err_reg;
        d1_next         = d1_reg;
        d2_next         = d2_reg;
        acc_next        = acc_reg;
        term_next       = term_reg;
        drive_next      = drive_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        code_next       = code_reg;
        clamp_next      = clamp_reg;
        m_valid_next    = m_valid_reg;
        m_code_next     = m_code_reg;
        m_drive_next    = m_drive_reg;
        m_clamp_next    = m_clamp_reg;
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;

        // gain writes
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:  kp_next = cfg_data;
                CFG_INTEG_GAIN: ki_next = cfg_data;
                CFG_DERIV_GAIN: kd_next = cfg_data;
                default: ;
            endcase
        end

        // output register drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    err_next   = {s_commanded_speed[SPEED_W-1], s_commanded_speed}
                               - {s_measured_speed[SPEED_W-1], s_measured_speed};
                    state_next = S_DIFF;
                end
            end

            // error differences, shift the error history
            S_DIFF: begin
                d1_next    = {err_reg[ERR_W-1], err_reg} - {e1_reg[ERR_W-1], e1_reg};
                d2_next    = {{2{err_reg[ERR_W-1]}}, err_reg}
                           - {e1_reg[ERR_W-1], e1_reg, 1'b0}
                           + {{2{e2_reg[ERR_W-1]}}, e2_reg};
                e2_next    = e1_reg;
                e1_next    = err_reg;
                acc_next   = {{(ACC_W-DRIVE_W){prev_drive_reg[DRIVE_W-1]}}, prev_drive_reg};
                term_next  = TERM_P;
                state_next = S_MUL;
            end

            // one gain term per pass
            S_MUL: begin
                mul_en = 1'b1;
                case (term_reg)
                    TERM_P: begin
                        mul_a = {{(MUL_W-GAIN_W){1'b0}}, kp_reg};
                        mul_b = {{(MUL_W-D1_W){d1_reg[D1_W-1]}}, d1_reg};
                    end
                    TERM_I: begin
                        mul_a = {{(MUL_W-GAIN_W){1'b0}}, ki_reg};
                        mul_b = {{(MUL_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                    end
                    default: begin
                        mul_a = {{(MUL_W-GAIN_W){1'b0}}, kd_reg};
                        mul_b = {{(MUL_W-D2_W){d2_reg[D2_W-1]}}, d2_reg};
                    end
                endcase
                state_next = S_ADD;
            end

            S_ADD: begin
                acc_next = acc_reg + mul_prod[ACC_W-1:0];
                if (term_reg == TERM_D) begin
                    state_next = S_SAT;
                end else begin
                    term_next  = term_reg + 2'd1;
                    state_next = S_MUL;
                end
            end

            // saturate to 32 bits and keep as the new drive
            S_SAT: begin
                if (acc_fits) begin
                    drive_next = acc_reg[DRIVE_W-1:0];
                end else if (acc_reg[ACC_W-1]) begin
                    drive_next = {1'b1, {(DRIVE_W-1){1'b0}}};
                end else begin
                    drive_next = {1'b0, {(DRIVE_W-1){1'b1}}};
                end
                prev_drive_next = drive_next;
                state_next      = S_SCALE;
            end

            // clamp checks, else start the reciprocal estimate
            S_SCALE: begin
                if (drive_reg[DRIVE_W-1]) begin
                    code_next  = '0;
                    clamp_next = 1'b1;
                    state_next = S_DONE;
                end else if (drive_reg >= DAC_CLAMP_DRIVE) begin
                    code_next  = DAC_CODE_MAX;
                    clamp_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    mul_en     = 1'b1;
                    mul_a      = drive_reg[MUL_W-1:0];
                    mul_b      = RECIP_MULT;
                    state_next = S_EST;
                end
            end

            // keep the estimate, start the exact scaling product
            S_EST: begin
                quo_next   = mul_prod[DAC_RECIP_SHIFT +: DAC_W];
                mul_en     = 1'b1;
                mul_a      = drive_reg[MUL_W-1:0];
                mul_b      = SCALE_MULT;
                state_next = S_LOAD;
            end

            // keep the scaling product, multiply the estimate back by the divisor
            S_LOAD: begin
                rem_next   = mul_prod;
                mul_en     = 1'b1;
                mul_a      = {{(MUL_W-DAC_W){1'b0}}, quo_reg};
                mul_b      = DEN_ODD_MULT;
                state_next = S_FIX;
            end

            // estimate is exact or one short
            S_FIX: begin
                code_next  = quo_reg + DAC_W'(fix_up);
                clamp_next = 1'b0;
                state_next = S_DONE;
            end

            // hand the word to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_code_next  = code_reg;
                    m_drive_next = drive_reg;
                    m_clamp_next = clamp_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            kp_reg         <= PROP_GAIN_RST;
            ki_reg         <= '0;
            kd_reg         <= '0;
            prev_drive_reg <= '0;
            e1_reg         <= '0;
            e2_reg         <= '0;
            term_reg       <= TERM_P;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            kp_reg         <= kp_next;
            ki_reg         <= ki_next;
            kd_reg         <= kd_next;
            prev_drive_reg <= prev_drive_next;
            e1_reg         <= e1_next;
            e2_reg         <= e2_next;
            term_reg       <= term_next;
            m_valid_reg    <= m_valid_next;
        end
        err_reg      <= err_next;
        d1_reg       <= d1_next;
        d2_reg       <= d2_next;
        acc_reg      <= acc_next;
        drive_reg    <= drive_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        code_reg     <= code_next;
        clamp_reg    <= clamp_next;
        m_code_reg   <= m_code_next;
        m_drive_reg  <= m_drive_next;
        m_clamp_reg  <= m_clamp_next;
    end

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_dac_code    = m_code_reg;
    assign m_drive_volts = m_drive_reg;
    assign m_dac_clamped = m_clamp_reg;

endmodule

`default_nettype wire

FILE: tb/tb_incremental_pid_dac_drive.sv
// tb_incremental_pid_dac_drive: self-checking bench for the velocity-form pid dac drive
// drives speed words and gain writes, predicts each drive word; needs ipdd_pkg and the rtl
`timescale 1ns / 100ps

module tb_incremental_pid_dac_drive;
    import ipdd_pkg::*;

    typedef struct {
        logic signed [SPEED_W-1:0] cmd;
        logic signed [SPEED_W-1:0] meas;
    } speed_word_t;

    typedef struct {
        logic [DAC_W-1:0]          dac;
        logic signed [DRIVE_W-1:0] volts;
        logic                      clamp;
    } drive_word_t;

    localparam longint DRIVE_HI = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_LO = -(longint'(1) <<< (DRIVE_W - 1));
    localparam logic [GAIN_W-1:0] GAIN_FULL = {GAIN_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int ERR_MAX = 65535;
    localparam int LONG_HOLD_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [GAIN_W-1:0]         cfg_data = '0;

    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [SPEED_W-1:0] s_commanded_speed = '0;
    logic signed [SPEED_W-1:0] s_measured_speed = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [DAC_W-1:0]          m_dac_code;
    logic signed [DRIVE_W-1:0] m_drive_volts;
    logic                      m_dac_clamped;

    // predictor copy of gains and loop state
    logic [GAIN_W-1:0]         gain_p = PROP_GAIN_RST;
    logic [GAIN_W-1:0]         gain_i = '0;
    logic [GAIN_W-1:0]         gain_d = '0;
    logic signed [DRIVE_W-1:0] model_drive = '0;
    logic signed [ERR_W-1:0]   model_err1 = '0;
    logic signed [ERR_W-1:0]   model_err2 = '0;

    speed_word_t pending_speed_q[$];
    drive_word_t expected_drive_q[$];
    speed_word_t next_word;
    drive_word_t got_word;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_request = 1'b0;
    bit hold_taken;
    int hold_left;
    int mismatch_count = 0;

    incremental_pid_dac_drive u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_commanded_speed (s_commanded_speed),
        .s_measured_speed  (s_measured_speed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_dac_code        (m_dac_code),
        .m_drive_volts     (m_drive_volts),
        .m_dac_clamped     (m_dac_clamped)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // next drive word from one speed word; advances the loop state
    task automatic predict_drive_word(input logic signed [SPEED_W-1:0] cmd,
                                      input logic signed [SPEED_W-1:0] meas);
        longint err;
        longint sum;
        longint q;
        drive_word_t w;
        err = longint'(cmd) - longint'(meas);
        sum = longint'(model_drive)
            + longint'(gain_p) * (err - longint'(model_err1))
            + longint'(gain_i) * err
            + longint'(gain_d) * (err - 2 * longint'(model_err1) + longint'(model_err2));
        // drive saturates at the 32-bit limits and is kept saturated
        if (sum > DRIVE_HI)
            w.volts = DRIVE_W'(DRIVE_HI);
        else if (sum < DRIVE_LO)
            w.volts = DRIVE_W'(DRIVE_LO);
        else
            w.volts = DRIVE_W'(sum);
        model_err2 = model_err1;
        model_err1 = ERR_W'(err);
        model_drive = w.volts;
        // dac scaling with clamp on both ends
        if (w.volts < 0) begin
            w.dac = '0;
            w.clamp = 1'b1;
        end else begin
            q = longint'(w.volts) * DAC_FULL_NUM / DAC_FULL_DEN;
            if (q > longint'(DAC_CODE_MAX)) begin
                w.dac = DAC_CODE_MAX;
                w.clamp = 1'b1;
            end else begin
                w.dac = DAC_W'(q);
                w.clamp = 1'b0;
            end
        end
        expected_drive_q.push_back(w);
    endtask

    // speed driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_drive_word(s_commanded_speed, s_measured_speed);
            if (!s_valid || s_ready) begin
                if (pending_speed_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    next_word = pending_speed_q.pop_front();
                    s_valid <= 1'b1;
                    s_commanded_speed <= next_word.cmd;
                    s_measured_speed <= next_word.meas;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // drive monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_drive_q.size() == 0) begin
                    $display("%0t unexpected drive word: dac %0d volts %0d clamp %0d",
                             $time, m_dac_code, m_drive_volts, m_dac_clamped);
                    mismatch_count++;
                end else begin
                    got_word = expected_drive_q.pop_front();
                    if (m_dac_code !== got_word.dac) begin
                        $display("%0t dac_code mismatch: expected %0d actual %0d",
                                 $time, got_word.dac, m_dac_code);
                        mismatch_count++;
                    end
                    if (m_drive_volts !== got_word.volts) begin
                        $display("%0t drive_volts mismatch: expected %0d actual %0d",
                                 $time, got_word.volts, m_drive_volts);
                        mismatch_count++;
                    end
                    if (m_dac_clamped !== got_word.clamp) begin
                        $display("%0t dac_clamped mismatch: expected %0d actual %0d",
                                 $time, got_word.clamp, m_dac_clamped);
                        mismatch_count++;
                    end
                end
            end
            // one long hold-off on request, otherwise random stalls
            if (hold_request && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left <= LONG_HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // gain write, mirrored into the predictor on acceptance
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PROP_GAIN:  gain_p = val;
            CFG_INTEG_GAIN: gain_i = val;
            CFG_DERIV_GAIN: gain_d = val;
            default: ;
        endcase
    endtask

    task automatic write_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd);
        write_gain(CFG_PROP_GAIN, kp);
        write_gain(CFG_INTEG_GAIN, ki);
        write_gain(CFG_DERIV_GAIN, kd);
    endtask

    // block idle: nothing queued, offered or outstanding
    task automatic wait_settled();
        do @(negedge aclk);
        while (pending_speed_q.size() != 0 || s_valid || expected_drive_q.size() != 0);
        repeat (2) @(negedge aclk);
    endtask

    task automatic push_speeds(input int cmd, input int meas);
        speed_word_t w;
        w.cmd = SPEED_W'(cmd);
        w.meas = SPEED_W'(meas);
        pending_speed_q.push_back(w);
    endtask

    // speed pair with a given error and a random common level
    task automatic push_error_word(input int err);
        int lo;
        int hi;
        int meas;
        lo = (err > 0) ? -32768 : -32768 - err;
        hi = (err > 0) ? 32767 - err : 32767;
        meas = lo + int'($urandom_range(0, hi - lo));
        push_speeds(meas + err, meas);
    endtask

    // pull the drive into the dac range with a single integral step, then zero the errors
    task automatic recenter_drive();
        longint target;
        longint err;
        target = longint'($urandom_range(330000, 100000));
        write_gains('0, GAIN_FULL, '0);
        err = (target - longint'(model_drive)) / longint'(GAIN_FULL);
        push_error_word(int'(err));
        push_error_word(0);
        push_error_word(0);
        wait_settled();
    endtask

    // error random walk around zero with some full-range noise
    task automatic run_walk_phase(input int n, input logic [GAIN_W-1:0] kp,
                                  input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd,
                                  input int step, input int tx, input int rx,
                                  input bit long_hold, input bit pause_mid);
        int err;
        tx_idle_pct = tx;
        rx_stall_pct = rx;
        recenter_drive();
        write_gains(kp, ki, kd);
        if (long_hold)
            hold_request = 1'b1;
        err = 0;
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2)
                wait_settled();
            if ($urandom_range(0, 99) < 15) begin
                push_speeds($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
            end else begin
                err = err + int'($urandom_range(0, 2 * step)) - step;
                if (err > ERR_MAX)
                    err = ERR_MAX;
                else if (err < -ERR_MAX)
                    err = -ERR_MAX;
                push_error_word(err);
            end
        end
        wait_settled();
    endtask

    // reset, phases, verdict
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset gains: zero drive, in-range codes, top boundary, both clamps
        push_speeds(0, 0);
        push_speeds(256, 0);
        push_speeds(1000, -600);
        push_speeds(1678, 0);
        push_speeds(1679, 0);
        push_speeds(-256, 0);
        push_speeds(32767, -32768);
        push_speeds(-32768, 32767);
        push_speeds(0, 0);
        wait_settled();

        // full gains: drive overflow in both directions
        write_gains(GAIN_FULL, GAIN_FULL, GAIN_FULL);
        push_speeds(32767, -32768);
        push_speeds(-32768, 32767);
        push_speeds(32767, -32768);
        push_speeds(-32768, 32767);
        push_speeds(0, 0);
        wait_settled();

        // zero gains hold the drive; a write past the register list changes nothing
        write_gains('0, '0, '0);
        write_gain(CFG_UNUSED, GAIN_FULL);
        push_speeds(12345, -2222);
        push_speeds(-32768, 32767);
        push_speeds(32767, -32768);
        wait_settled();

        // random phases
        run_walk_phase(120, GAIN_W'($urandom_range(1024, 64)), GAIN_W'($urandom_range(8, 0)),
                       GAIN_W'($urandom_range(512, 0)), 64, 0, 0, 1'b1, 1'b0);
        run_walk_phase(120, GAIN_W'($urandom_range(1024, 64)), GAIN_W'($urandom_range(8, 0)),
                       GAIN_W'($urandom_range(512, 0)), 64, 62, 0, 1'b0, 1'b0);
        run_walk_phase(120, GAIN_W'($urandom_range(65535, 0)),
                       GAIN_W'($urandom_range(65535, 0)),
                       GAIN_W'($urandom_range(65535, 0)), 4096, 0, 62, 1'b0, 1'b0);
        run_walk_phase(120, GAIN_W'($urandom_range(2048, 16)), GAIN_W'($urandom_range(16, 0)),
                       GAIN_W'($urandom_range(1024, 0)), 128, 11, 11, 1'b0, 1'b1);
        run_walk_phase(120, GAIN_W'(1), GAIN_W'(1), GAIN_W'(1), 8192, 0, 0, 1'b0, 1'b0);

        wait_settled();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && expected_drive_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: incremental_pid_dac_drive.f
rtl/ipdd_pkg.sv
rtl/ipdd_mul.sv
rtl/incremental_pid_dac_drive.sv
tb/tb_incremental_pid_dac_drive.sv
